// File: rtl/bss_pkg.sv
package bss_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int SAMPLE_W    = 8;
    localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int MID_W       = $clog2(MAX_SAMPLES / 2 + 1);
    localparam int SUM_W       = $clog2(MAX_SAMPLES * 255 + 1);
    localparam int FRAC_W      = 8;
    localparam int DIVIDEND_W  = SUM_W + FRAC_W;
    localparam int MEAN_W      = 16;
    localparam int MEDIAN_W    = SAMPLE_W + 1;
    localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);
    // finishing pass must cover both the median walk and the divider
    localparam int FIN_LAST    = ((MAX_SAMPLES / 2 > DIVIDEND_W) ?
                                  MAX_SAMPLES / 2 : DIVIDEND_W) + 1;
    localparam int STEP_W      = $clog2(FIN_LAST + 1);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] minimum;
        logic [SAMPLE_W-1:0] maximum;
        logic [MEAN_W-1:0]   mean_q8;
        logic [MEDIAN_W-1:0] median_x2;
        logic [COUNT_W-1:0]  sample_count;
        logic                overflow;
    } result_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_FINISH = 2'b10
    } state_t;

endpackage

// File: rtl/bss_cell.sv
module bss_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bss_pkg::cell_cmd_t            cmd,
    input  logic [bss_pkg::SAMPLE_W-1:0]  sample,
    input  logic [bss_pkg::SAMPLE_W-1:0]  prev_val,
    input  logic                          prev_valid,
    input  logic [bss_pkg::SAMPLE_W-1:0]  next_val,
    input  logic                          next_valid,
    output logic [bss_pkg::SAMPLE_W-1:0]  val,
    output logic                          valid
);

    logic [bss_pkg::SAMPLE_W-1:0] val_reg, val_next;
    logic                         valid_reg, valid_next;
    logic                         here_greater, prev_greater;

    // an empty cell counts as larger than any byte
    assign here_greater = !valid_reg || (val_reg > sample);
    assign prev_greater = !prev_valid || (prev_val > sample);

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (cmd.clear)
        begin
            valid_next = 1'b0;
        end
        else if (cmd.shift)
        begin
            val_next   = next_val;
            valid_next = next_valid;
        end
        else if (cmd.insert)
        begin
            if (prev_greater)
            begin
                val_next   = prev_val;
                valid_next = prev_valid;
            end
            else if (here_greater)
            begin
                val_next   = sample;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val   = val_reg;
    assign valid = valid_reg;

endmodule

// File: rtl/bss_div.sv
module bss_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [bss_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [bss_pkg::COUNT_W-1:0]     divisor,
    output logic [bss_pkg::MEAN_W-1:0]      quotient
);

    logic [bss_pkg::DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [bss_pkg::COUNT_W-1:0]    rem_reg, rem_next;
    logic [bss_pkg::COUNT_W-1:0]    dsr_reg, dsr_next;
    logic [bss_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [bss_pkg::COUNT_W:0]      rem_shift;
    logic                           fits;

    // one quotient bit per cycle, restoring
    assign rem_shift = {rem_reg, quo_reg[bss_pkg::DIVIDEND_W-1]};
    assign fits      = (rem_shift >= {1'b0, dsr_reg});

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = bss_pkg::DIV_CNT_W'(bss_pkg::DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            quo_next = {quo_reg[bss_pkg::DIVIDEND_W-2:0], fits};
            rem_next = fits ? bss_pkg::COUNT_W'(rem_shift - {1'b0, dsr_reg})
                            : rem_shift[bss_pkg::COUNT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg[bss_pkg::MEAN_W-1:0];

endmodule

// File: rtl/byte_set_statistics.sv
// a word with last starts the finishing pass, and its result is registered when the
// step counter reaches FIN_LAST (median walk along the cell chain and
// a one-bit-per-cycle divider run in parallel during the finishing pass)
// throughput: 1 word per cycle inside a set, busy through the finishing pass
// reset clears count, max, sum, overflow and all cell valid bits and sets min to all ones at once
// the receiver cannot stall: result_valid is high for exactly one cycle
module byte_set_statistics (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bss_pkg::item_t    item,
    output logic              busy,
    output logic              result_valid,
    output bss_pkg::result_t  result
);

    localparam int N = bss_pkg::MAX_SAMPLES;

    bss_pkg::state_t                state_reg, state_next;
    logic [bss_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [bss_pkg::SAMPLE_W-1:0]   min_reg, min_next;
    logic [bss_pkg::SAMPLE_W-1:0]   max_reg, max_next;
    logic [bss_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic                           drop_reg, drop_next;
    logic [bss_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [bss_pkg::SAMPLE_W-1:0]   lo_reg, lo_next;
    logic [bss_pkg::SAMPLE_W-1:0]   hi_reg, hi_next;
    bss_pkg::result_t               result_reg, result_next;
    logic                           rvalid_reg, rvalid_next;

    logic                           accept, full, keep, emit;
    logic [bss_pkg::MID_W-1:0]      mid_hi, mid_lo;
    logic [bss_pkg::MEAN_W-1:0]     quotient;
    bss_pkg::cell_cmd_t             cmd;

    logic [bss_pkg::SAMPLE_W-1:0]   chain_val [N+1];
    logic                           chain_valid [N+1];

    assign accept = start && (state_reg == bss_pkg::ST_IDLE);
    assign full   = (count_reg == bss_pkg::COUNT_W'(N));
    assign keep   = accept && !full;
    assign emit   = (state_reg == bss_pkg::ST_FINISH) &&
                    (step_reg == bss_pkg::STEP_W'(bss_pkg::FIN_LAST));

    // indexes of the middle pair; equal for an odd count
    assign mid_hi = count_reg[bss_pkg::MID_W:1];
    assign mid_lo = count_reg[0] ? mid_hi : mid_hi - 1'b1;

    assign cmd.insert = keep;
    assign cmd.shift  = (state_reg == bss_pkg::ST_FINISH);
    assign cmd.clear  = emit;

    assign chain_val[N]   = '0;
    assign chain_valid[N] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            logic [bss_pkg::SAMPLE_W-1:0] prev_val;
            logic                         prev_valid;
            if (gi == 0)
            begin : g_head
                // head sees a zero that is never greater than the new byte
                assign prev_val   = '0;
                assign prev_valid = 1'b1;
            end
            else
            begin : g_body
                assign prev_val   = chain_val[gi-1];
                assign prev_valid = chain_valid[gi-1];
            end
            bss_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .sample     (item.sample),
                .prev_val   (prev_val),
                .prev_valid (prev_valid),
                .next_val   (chain_val[gi+1]),
                .next_valid (chain_valid[gi+1]),
                .val        (chain_val[gi]),
                .valid      (chain_valid[gi])
            );
        end
    endgenerate

    bss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    ((state_reg == bss_pkg::ST_FINISH) && (step_reg == '0)),
        .dividend ({sum_reg, {bss_pkg::FRAC_W{1'b0}}}),
        .divisor  (count_reg),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        sum_next    = sum_reg;
        drop_next   = drop_reg;
        step_next   = step_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        result_next = result_reg;
        rvalid_next = 1'b0;
        case (state_reg)
            bss_pkg::ST_IDLE:
            begin
                if (keep)
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + bss_pkg::SUM_W'(item.sample);
                    if (item.sample < min_reg)
                    begin
                        min_next = item.sample;
                    end
                    if (item.sample > max_reg)
                    begin
                        max_next = item.sample;
                    end
                end
                else if (accept)
                begin
                    drop_next = 1'b1;
                end
                if (accept && item.last)
                begin
                    state_next = bss_pkg::ST_FINISH;
                    step_next  = '0;
                end
            end
            bss_pkg::ST_FINISH:
            begin
                // head cell holds the sorted entry at index step_reg
                if (step_reg == bss_pkg::STEP_W'(mid_lo))
                begin
                    lo_next = chain_val[0];
                end
                if (step_reg == bss_pkg::STEP_W'(mid_hi))
                begin
                    hi_next = chain_val[0];
                end
                step_next = step_reg + 1'b1;
                if (emit)
                begin
                    result_next.minimum      = min_reg;
                    result_next.maximum      = max_reg;
                    result_next.sample_count = count_reg;
                    result_next.overflow     = drop_reg;
                    if (count_reg == '0)
                    begin
                        result_next.mean_q8   = '0;
                        result_next.median_x2 = '0;
                    end
                    else
                    begin
                        result_next.mean_q8   = quotient;
                        result_next.median_x2 = {1'b0, lo_reg} + {1'b0, hi_reg};
                    end
                    rvalid_next = 1'b1;
                    state_next  = bss_pkg::ST_IDLE;
                    count_next  = '0;
                    min_next    = '1;
                    max_next    = '0;
                    sum_next    = '0;
                    drop_next   = 1'b0;
                    step_next   = '0;
                end
            end
            default:
            begin
                state_next = bss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bss_pkg::ST_IDLE;
            count_reg  <= '0;
            min_reg    <= '1;
            max_reg    <= '0;
            sum_reg    <= '0;
            drop_reg   <= 1'b0;
            step_reg   <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
            sum_reg    <= sum_next;
            drop_reg   <= drop_next;
            step_reg   <= step_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        result_reg <= result_next;
    end

    assign busy         = (state_reg != bss_pkg::ST_IDLE);
    assign result_valid = rvalid_reg;
    assign result       = result_reg;

endmodule

// File: rtl/bss_checker.sv
module bss_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bss_pkg::item_t    item,
    input  logic              busy,
    input  logic              result_valid,
    input  bss_pkg::result_t  result
);

    // a result only comes at the end of a finishing pass
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ($past(busy) && !busy))
        else $error("result without a finishing pass");

    // a word without last never starts a finishing pass
    a_plain_word_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.last) |=> !busy)
        else $error("busy after a word without last");

    // a word with last always starts one
    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last) |=> busy)
        else $error("no finishing pass after last word");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.sample_count != '0 &&
                          result.sample_count <= bss_pkg::COUNT_W'(bss_pkg::MAX_SAMPLES)))
        else $error("sample count out of range");

    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.minimum <= result.maximum &&
                          result.median_x2 >= {1'b0, result.minimum} + {1'b0, result.minimum}))
        else $error("minimum, maximum or median inconsistent");

endmodule

bind byte_set_statistics bss_checker u_bss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
